// ----- rtl/core/owm_pkg.sv -----
// Shared types and constants for the one-wire temperature sensor master.
// No dependencies; imported by owm_core, owm_obuf and the top level.
package owm_pkg;

  localparam int CFG_W      = 12;
  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int TICK_W_DEF = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_RESET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_HOLD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd7;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL [NUM_CFG] = '{
    12'd870, 12'd78, 12'd400, 12'd1000, 12'd6, 12'd63, 12'd2, 12'd52
  };

  // Command codes.
  localparam logic [2:0] OP_RESET     = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_CONVERT   = 3'd3;
  localparam logic [2:0] OP_READ_TEMP = 3'd4;
  localparam logic [2:0] OP_CONFIGURE = 3'd5;

  // Sensor command bytes.
  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
  localparam logic [7:0] CMD_WRITE_PAD = 8'h4E;
  localparam logic [7:0] CFG_12BIT     = 8'h7F;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_POST     = 4'd4,
    PH_W_LOW    = 4'd5,
    PH_W_REC    = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_WAIT   = 4'd8,
    PH_R_TAIL   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_END   = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic        dq_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        present;
    logic [7:0]  read_data;
    logic [15:0] temperature;
  } result_t;

endpackage

// ----- rtl/core/owm_core.sv -----
// Bus sequencer of the one-wire master: configuration registers, command
// state and the single-pass update per tick. Depends on owm_pkg.
module owm_core #(
  parameter int TICK_COUNT_WIDTH = owm_pkg::TICK_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_en,
  input  logic                          start_req,
  input  logic [2:0]                    operation,
  input  logic [7:0]                    write_data,
  input  logic                          dq_sample,
  input  logic                          cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data,
  output owm_pkg::result_t              result
);
  import owm_pkg::*;

  localparam int TW = TICK_COUNT_WIDTH;
  localparam int LW = (TW > CFG_W) ? TW : CFG_W;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] sb;
    logic       done;
  } nb_t;

  logic [CFG_W-1:0] cfg_q [NUM_CFG];

  phase_t        phase, phase_next;
  logic [TW-1:0] tick_count, tick_count_next;
  logic [2:0]    bit_index, bit_index_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [2:0]    byte_step, byte_step_next;
  logic [2:0]    active_op, active_op_next;
  logic          presence_flag, presence_flag_next;
  logic [7:0]    temp_low, temp_low_next;
  logic [7:0]    temp_high, temp_high_next;
  logic [7:0]    last_read, last_read_next;

  // Clip a register value to what the tick counter can hold.
  function automatic logic [TW-1:0] clip(input logic [CFG_W-1:0] v);
    logic [LW-1:0] ext;
    logic [LW-1:0] mx;
    ext = LW'(v);
    mx  = LW'({TW{1'b1}});
    if (ext > mx) ext = mx;
    return TW'(ext);
  endfunction

  function automatic logic [TW-1:0] dur(input logic [CFG_W-1:0] v);
    return clip((v == '0) ? CFG_W'(1) : v);
  endfunction

  // Chooses the next byte of the command and the phase that sends it.
  function automatic nb_t next_byte(input logic [2:0] op, input logic [2:0] step,
                                    input logic [7:0] sb);
    kind_t      kind;
    logic [7:0] val;
    nb_t        r;
    kind = KIND_END;
    val  = 8'h00;
    case (op)
      OP_WRITE: begin
        if (step == 3'd0) begin
          kind = KIND_WRITE;
          val  = sb;
        end
      end
      OP_READ: begin
        if (step == 3'd0) kind = KIND_READ;
      end
      OP_CONVERT: begin
        if (step == 3'd0) begin
          kind = KIND_WRITE;
          val  = CMD_SKIP_ROM;
        end else if (step == 3'd1) begin
          kind = KIND_WRITE;
          val  = CMD_CONVERT;
        end
      end
      OP_READ_TEMP: begin
        if (step == 3'd0) begin
          kind = KIND_WRITE;
          val  = CMD_SKIP_ROM;
        end else if (step == 3'd1) begin
          kind = KIND_WRITE;
          val  = CMD_READ_PAD;
        end else if (step < 3'd4) begin
          kind = KIND_READ;
        end
      end
      OP_CONFIGURE: begin
        kind = (step < 3'd5) ? KIND_WRITE : KIND_END;
        case (step)
          3'd0:    val = CMD_SKIP_ROM;
          3'd1:    val = CMD_WRITE_PAD;
          3'd4:    val = CFG_12BIT;
          default: val = 8'h00;
        endcase
      end
      default: kind = KIND_END;
    endcase
    r.done = 1'b0;
    unique case (kind)
      KIND_WRITE: begin
        r.phase = PH_W_LOW;
        r.sb    = val;
      end
      KIND_READ: begin
        r.phase = PH_R_LOW;
        r.sb    = 8'h00;
      end
      default: begin
        r.phase = PH_IDLE;
        r.sb    = sb;
        r.done  = 1'b1;
      end
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= CFG_RESET_VAL[i];
    end else if (cfg_we) begin
      cfg_q[cfg_index] <= cfg_data;
    end
  end

  logic          bit1;
  logic [TW-1:0] lim;
  logic [TW-1:0] tick_inc;
  logic          hit;
  logic          bit_done;
  logic          reading;
  logic          done;
  logic [2:0]    step_inc;
  nb_t           nb;

  assign bit1     = shift_byte[0];
  assign tick_inc = tick_count + 1'b1;
  assign hit      = (tick_inc >= lim);
  assign step_inc = byte_step + 1'b1;

  // Limit of the phase in effect; one comparator serves every timed phase.
  always_comb begin
    case (phase)
      PH_RST_LOW:  lim = dur(cfg_q[CFG_RESET_LOW]);
      PH_RST_WAIT: lim = dur(cfg_q[CFG_PRESENCE_SMP]);
      PH_RST_TAIL: lim = dur(cfg_q[CFG_RESET_TAIL]);
      PH_POST:     lim = clip(cfg_q[CFG_POST_RESET]);
      PH_W_LOW:    lim = bit1 ? dur(cfg_q[CFG_SHORT]) : dur(cfg_q[CFG_SLOT_HOLD]);
      PH_W_REC:    lim = bit1 ? dur(cfg_q[CFG_SLOT_HOLD]) : dur(cfg_q[CFG_RELEASE]);
      PH_R_LOW:    lim = dur(cfg_q[CFG_RELEASE]);
      PH_R_WAIT:   lim = dur(cfg_q[CFG_SHORT]);
      PH_R_TAIL:   lim = dur(cfg_q[CFG_READ_TAIL]);
      default:     lim = '1;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    byte_step_next     = byte_step;
    active_op_next     = active_op;
    presence_flag_next = presence_flag;
    temp_low_next      = temp_low;
    temp_high_next     = temp_high;
    last_read_next     = last_read;
    done               = 1'b0;
    bit_done           = 1'b0;
    reading            = 1'b0;
    nb                 = '0;

    unique case (phase)
      PH_IDLE: begin
        if (start_req && operation <= OP_CONFIGURE) begin
          active_op_next  = operation;
          byte_step_next  = 3'd0;
          tick_count_next = '0;
          if (operation == OP_WRITE || operation == OP_READ) begin
            nb = next_byte(operation, 3'd0,
                           (operation == OP_WRITE) ? write_data : shift_byte);
            phase_next      = nb.phase;
            shift_byte_next = nb.sb;
            bit_index_next  = 3'd0;
            done            = nb.done;
          end else begin
            phase_next = PH_RST_LOW;
          end
        end
      end
      PH_RST_LOW: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) phase_next = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) begin
          presence_flag_next = ~dq_sample;
          phase_next         = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) begin
          if (active_op == OP_RESET || !presence_flag) begin
            if (active_op == OP_READ_TEMP) begin
              temp_low_next  = 8'h00;
              temp_high_next = 8'h00;
            end
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else if (cfg_q[CFG_POST_RESET] == '0) begin
            nb              = next_byte(active_op, byte_step, shift_byte);
            phase_next      = nb.phase;
            shift_byte_next = nb.sb;
            bit_index_next  = 3'd0;
            done            = nb.done;
          end else begin
            phase_next = PH_POST;
          end
        end
      end
      PH_POST: begin
        // A zero post-reset time written while waiting ends the wait at once.
        if (cfg_q[CFG_POST_RESET] == '0 || hit) begin
          tick_count_next = '0;
          nb              = next_byte(active_op, byte_step, shift_byte);
          phase_next      = nb.phase;
          shift_byte_next = nb.sb;
          bit_index_next  = 3'd0;
          done            = nb.done;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_W_LOW: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) phase_next = PH_W_REC;
      end
      PH_W_REC: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) begin
          shift_byte_next = {1'b0, shift_byte[7:1]};
          bit_done        = 1'b1;
        end
      end
      PH_R_LOW: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) phase_next = PH_R_WAIT;
      end
      PH_R_WAIT: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) begin
          shift_byte_next = {dq_sample, shift_byte[7:1]};
          phase_next      = PH_R_TAIL;
        end
      end
      PH_R_TAIL: begin
        tick_count_next = hit ? '0 : tick_inc;
        if (hit) begin
          bit_done = 1'b1;
          reading  = 1'b1;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    // End of a bit slot: move to the next bit, or close the byte.
    if (bit_done) begin
      if (bit_index < 3'd7) begin
        bit_index_next = bit_index + 1'b1;
        phase_next     = reading ? PH_R_LOW : PH_W_LOW;
      end else begin
        if (reading) begin
          if (active_op == OP_READ) last_read_next = shift_byte_next;
          else if (byte_step == 3'd2) temp_low_next = shift_byte_next;
          else if (byte_step == 3'd3) temp_high_next = shift_byte_next;
        end
        byte_step_next  = step_inc;
        nb              = next_byte(active_op, step_inc, shift_byte_next);
        phase_next      = nb.phase;
        shift_byte_next = nb.sb;
        bit_index_next  = 3'd0;
        done            = nb.done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      byte_step     <= '0;
      active_op     <= '0;
      presence_flag <= 1'b0;
      temp_low      <= '0;
      temp_high     <= '0;
      last_read     <= '0;
    end else if (step_en) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      byte_step     <= byte_step_next;
      active_op     <= active_op_next;
      presence_flag <= presence_flag_next;
      temp_low      <= temp_low_next;
      temp_high     <= temp_high_next;
      last_read     <= last_read_next;
    end
  end

  always_comb begin
    result.dq_pull_low = (phase == PH_RST_LOW) || (phase == PH_W_LOW) ||
                         (phase == PH_R_LOW);
    result.busy_res    = (phase != PH_IDLE);
    result.done_res    = done;
    result.present     = presence_flag_next;
    result.read_data   = last_read_next;
    result.temperature = {temp_high_next, temp_low_next};
  end

endmodule

// ----- rtl/core/owm_obuf.sv -----
// Two-entry output buffer: an output register backed by a skid register.
// Depends on owm_pkg for the result type.
module owm_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  owm_pkg::result_t in_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output owm_pkg::result_t out_data
);
  import owm_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    out_open;

  assign out_open = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_open) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

// ----- rtl/core/one_wire_temp_sensor_master.sv -----
// Top level of the one-wire temperature sensor master.
// Depends on owm_pkg, owm_core and owm_obuf.
//
// One input transfer is one bus timing tick, and every tick gives exactly one
// result transfer. A tick can be taken in every clock cycle while in_stall
// is low: the sequencer state is updated in one pass per tick, and its result
// is registered in the output register. A skid register behind that output
// lets one more tick in while a result is held by out_stall, so in_stall
// rises only when both entries are full. Configuration writes are taken in
// any cycle (cfg_ready is always high) and should be issued only while no
// command is running.
module one_wire_temp_sensor_master #(
  parameter int TICK_COUNT_WIDTH = owm_pkg::TICK_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          start_req,
  input  logic [2:0]                    operation,
  input  logic [7:0]                    write_data,
  input  logic                          dq_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          dq_pull_low,
  output logic                          busy_res,
  output logic                          done_res,
  output logic                          present,
  output logic [7:0]                    read_data,
  output logic [15:0]                   temperature,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);
  import owm_pkg::*;

  logic    in_fire;
  logic    buf_full;
  result_t step_result;
  result_t out_result;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_fire   = in_valid && !buf_full;

  owm_core #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (in_fire),
    .start_req  (start_req),
    .operation  (operation),
    .write_data (write_data),
    .dq_sample  (dq_sample),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .result     (step_result)
  );

  owm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (step_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_result)
  );

  assign dq_pull_low = out_result.dq_pull_low;
  assign busy_res    = out_result.busy_res;
  assign done_res    = out_result.done_res;
  assign present     = out_result.present;
  assign read_data   = out_result.read_data;
  assign temperature = out_result.temperature;

endmodule

// ----- rtl/core/owm_checker.sv -----
// Port-level checks for the one-wire temperature sensor master, and the bind
// that attaches them to the top level. No package dependency.
module owm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        dq_pull_low,
  input logic        busy_res,
  input logic        done_res,
  input logic        present,
  input logic [7:0]  read_data,
  input logic [15:0] temperature
);

  // The input side stalls only when a result is already waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no result waiting");

  // Every accepted tick leaves a result on the output next cycle.
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no result");

  // Completion and bus drive only happen on ticks that a command occupies.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (done_res || dq_pull_low)) |-> busy_res)
    else $error("done or bus drive reported on an idle tick");

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(temperature) &&
      $stable(read_data) && $stable(present) && $stable(done_res)))
    else $error("stalled result changed");

endmodule

bind one_wire_temp_sensor_master owm_checker u_owm_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for one_wire_temp_sensor_master: streams bus ticks under random
// idling and stalls, and checks every per-tick result against a cycle model.
// Depends on owm_pkg and the block's RTL.
module testbench;
  import owm_pkg::*;

  localparam logic [2:0] OP_BAD_LO    = 3'd6;
  localparam logic [2:0] OP_BAD_HI    = 3'd7;
  localparam logic [2:0] TEMP_LO_STEP = 3'd2;
  localparam logic [2:0] TEMP_HI_STEP = 3'd3;
  localparam int BITS_LOW    = 0;
  localparam int BITS_HIGH   = 1;
  localparam int BITS_RANDOM = 2;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic       start;
    logic [2:0] op;
    logic [7:0] data;
    logic       dq;
  } tick_t;

  typedef struct packed {
    logic [NUM_CFG-1:0][CFG_W-1:0] cfg;
    phase_t                        phase;
    logic [CFG_W-1:0]              ticks;
    logic [2:0]                    bit_idx;
    logic [7:0]                    shifter;
    logic [2:0]                    step;
    logic [2:0]                    op;
    logic                          presence;
    logic [7:0]                    t_lo;
    logic [7:0]                    t_hi;
    logic [7:0]                    last_rd;
  } sensor_state_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              start_req = 1'b0;
  logic [2:0]        operation = OP_RESET;
  logic [7:0]        write_data = '0;
  logic              dq_sample = 1'b1;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              dq_pull_low;
  logic              busy_res;
  logic              done_res;
  logic              present;
  logic [7:0]        read_data;
  logic [15:0]       temperature;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  sensor_state_t sensor;
  sensor_state_t lookahead;
  tick_t         pending_ticks[$];
  result_t       tick_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int presence_pct   = 80;
  int bit_mode       = BITS_RANDOM;
  int errors         = 0;
  int ticks_done     = 0;
  int commands_done  = 0;
  int presence_seen  = 0;
  int settings_run   = 1;
  int quiet_cycles   = 0;

  one_wire_temp_sensor_master i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_req   (start_req),
    .operation   (operation),
    .write_data  (write_data),
    .dq_sample   (dq_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dq_pull_low (dq_pull_low),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .present     (present),
    .read_data   (read_data),
    .temperature (temperature),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sensor_state_t fresh_state();
    sensor_state_t s;
    s = '0;
    for (int i = 0; i < NUM_CFG; i++) s.cfg[i] = CFG_RESET_VAL[i];
    s.phase = PH_IDLE;
    return s;
  endfunction

  // A programmed duration of zero still lasts one tick.
  function automatic logic [CFG_W-1:0] span(input logic [CFG_W-1:0] v);
    return (v == '0) ? CFG_W'(1) : v;
  endfunction

  function automatic logic count_up(inout sensor_state_t s, input logic [CFG_W-1:0] lim);
    s.ticks = s.ticks + 1'b1;
    if (s.ticks >= lim) begin
      s.ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic kind_t byte_plan(input sensor_state_t s, output logic [7:0] val);
    val = '0;
    case (s.op)
      OP_WRITE: begin
        if (s.step == 0) begin
          val = s.shifter;
          return KIND_WRITE;
        end
      end
      OP_READ: begin
        if (s.step == 0) return KIND_READ;
      end
      OP_CONVERT: begin
        if (s.step < 2) begin
          val = (s.step == 0) ? CMD_SKIP_ROM : CMD_CONVERT;
          return KIND_WRITE;
        end
      end
      OP_READ_TEMP: begin
        if (s.step < 2) begin
          val = (s.step == 0) ? CMD_SKIP_ROM : CMD_READ_PAD;
          return KIND_WRITE;
        end
        if (s.step <= TEMP_HI_STEP) return KIND_READ;
      end
      OP_CONFIGURE: begin
        if (s.step < 5) begin
          case (s.step)
            3'd0:    val = CMD_SKIP_ROM;
            3'd1:    val = CMD_WRITE_PAD;
            3'd4:    val = CFG_12BIT;
            default: val = '0;
          endcase
          return KIND_WRITE;
        end
      end
      default: ;
    endcase
    return KIND_END;
  endfunction

  function automatic void end_command(inout sensor_state_t s, inout logic done);
    s.phase = PH_IDLE;
    s.ticks = '0;
    done = 1'b1;
  endfunction

  function automatic void load_next_byte(inout sensor_state_t s, inout logic done);
    logic [7:0] val;
    kind_t      kind;
    kind = byte_plan(s, val);
    s.bit_idx = '0;
    s.ticks = '0;
    case (kind)
      KIND_WRITE: begin
        s.shifter = val;
        s.phase = PH_W_LOW;
      end
      KIND_READ: begin
        s.shifter = '0;
        s.phase = PH_R_LOW;
      end
      default: end_command(s, done);
    endcase
  endfunction

  function automatic void finish_bit(inout sensor_state_t s, input logic reading,
                                     inout logic done);
    if (s.bit_idx < 3'd7) begin
      s.bit_idx = s.bit_idx + 1'b1;
      s.phase = reading ? PH_R_LOW : PH_W_LOW;
      return;
    end
    if (reading) begin
      if (s.op == OP_READ) s.last_rd = s.shifter;
      else if (s.step == TEMP_LO_STEP) s.t_lo = s.shifter;
      else if (s.step == TEMP_HI_STEP) s.t_hi = s.shifter;
    end
    s.step = s.step + 1'b1;
    load_next_byte(s, done);
  endfunction

  // One bus tick: the drive and the busy flag reflect the phase the tick started in, the
  // other flags and data reflect the state after it.
  function automatic result_t sensor_tick(inout sensor_state_t s, input tick_t t);
    result_t r;
    logic    done;
    logic    bit1;
    r.dq_pull_low = (s.phase == PH_RST_LOW || s.phase == PH_W_LOW || s.phase == PH_R_LOW);
    r.busy_res = (s.phase != PH_IDLE);
    bit1 = s.shifter[0];
    done = 1'b0;
    case (s.phase)
      PH_IDLE: begin
        if (t.start && t.op <= OP_CONFIGURE) begin
          s.op = t.op;
          s.step = '0;
          s.ticks = '0;
          if (t.op == OP_WRITE) begin
            s.shifter = t.data;
            load_next_byte(s, done);
          end else if (t.op == OP_READ) begin
            load_next_byte(s, done);
          end else begin
            s.phase = PH_RST_LOW;
          end
        end
      end
      PH_RST_LOW: begin
        if (count_up(s, span(s.cfg[CFG_RESET_LOW]))) s.phase = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (count_up(s, span(s.cfg[CFG_PRESENCE_SMP]))) begin
          s.presence = ~t.dq;
          s.phase = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        if (count_up(s, span(s.cfg[CFG_RESET_TAIL]))) begin
          if (s.op == OP_RESET) begin
            end_command(s, done);
          end else if (!s.presence) begin
            // Nobody answered: a temperature read reports zero.
            if (s.op == OP_READ_TEMP) begin
              s.t_lo = '0;
              s.t_hi = '0;
            end
            end_command(s, done);
          end else if (s.cfg[CFG_POST_RESET] == '0) begin
            load_next_byte(s, done);
          end else begin
            s.phase = PH_POST;
          end
        end
      end
      PH_POST: begin
        if (s.cfg[CFG_POST_RESET] == '0) load_next_byte(s, done);
        else if (count_up(s, s.cfg[CFG_POST_RESET])) load_next_byte(s, done);
      end
      PH_W_LOW: begin
        if (count_up(s, span(bit1 ? s.cfg[CFG_SHORT] : s.cfg[CFG_SLOT_HOLD])))
          s.phase = PH_W_REC;
      end
      PH_W_REC: begin
        if (count_up(s, span(bit1 ? s.cfg[CFG_SLOT_HOLD] : s.cfg[CFG_RELEASE]))) begin
          s.shifter = s.shifter >> 1;
          finish_bit(s, 1'b0, done);
        end
      end
      PH_R_LOW: begin
        if (count_up(s, span(s.cfg[CFG_RELEASE]))) s.phase = PH_R_WAIT;
      end
      PH_R_WAIT: begin
        if (count_up(s, span(s.cfg[CFG_SHORT]))) begin
          s.shifter = {t.dq, s.shifter[7:1]};
          s.phase = PH_R_TAIL;
        end
      end
      PH_R_TAIL: begin
        if (count_up(s, span(s.cfg[CFG_READ_TAIL]))) finish_bit(s, 1'b1, done);
      end
      default: begin
        s.phase = PH_IDLE;
        s.ticks = '0;
      end
    endcase
    r.done_res = done;
    r.present = s.presence;
    r.read_data = s.last_rd;
    r.temperature = {s.t_hi, s.t_lo};
    return r;
  endfunction

  // Bus level as a sensor would leave it: presence is pulled low by chance, data bits
  // follow the selected pattern.
  function automatic logic bus_level();
    if (lookahead.phase == PH_RST_WAIT) return ($urandom_range(99) >= presence_pct);
    if (bit_mode == BITS_RANDOM) return 1'($urandom_range(1));
    return (bit_mode == BITS_HIGH);
  endfunction

  function automatic tick_t bus_tick();
    tick_t t;
    t.start = ($urandom_range(99) < 15);
    t.op = 3'($urandom_range(7));
    t.data = 8'($urandom);
    t.dq = bus_level();
    return t;
  endfunction

  task automatic push_tick(input tick_t t);
    void'(sensor_tick(lookahead, t));
    pending_ticks.push_back(t);
  endtask

  task automatic queue_command(input logic [2:0] op, input logic [7:0] data);
    tick_t t;
    while (lookahead.phase != PH_IDLE) push_tick(bus_tick());
    t = bus_tick();
    t.start = 1'b1;
    t.op = op;
    t.data = data;
    push_tick(t);
    while (lookahead.phase != PH_IDLE) push_tick(bus_tick());
  endtask

  task automatic queue_random(input int n);
    tick_t t;
    repeat (n) begin
      t = bus_tick();
      if (lookahead.phase == PH_IDLE && $urandom_range(99) < 30) begin
        t.start = 1'b1;
        t.op = ($urandom_range(9) == 0) ? 3'($urandom_range(OP_BAD_HI, OP_BAD_LO))
                                         : 3'($urandom_range(OP_CONFIGURE, OP_RESET));
      end
      push_tick(t);
    end
    while (lookahead.phase != PH_IDLE) push_tick(bus_tick());
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || in_valid || tick_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sensor.cfg[idx] = val;
    lookahead.cfg[idx] = val;
  endtask

  // Reset and post-reset timings come from one range, the slot timings from another.
  task automatic program_regs(input int head_lo, input int head_hi,
                              input int slot_lo, input int slot_hi);
    settle();
    for (int i = 0; i < NUM_CFG; i++) begin
      if (i <= CFG_POST_RESET) write_reg(i, CFG_W'($urandom_range(head_hi, head_lo)));
      else write_reg(i, CFG_W'($urandom_range(slot_hi, slot_lo)));
    end
    settings_run++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  always @(posedge clk) begin : drive
    tick_t pending;
    tick_t taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken = {start_req, operation, write_data, dq_sample};
        tick_results.push_back(sensor_tick(sensor, taken));
      end
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pending = pending_ticks.pop_front();
          in_valid <= 1'b1;
          start_req <= pending.start;
          operation <= pending.op;
          write_data <= pending.data;
          dq_sample <= pending.dq;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : observe
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        ticks_done++;
        if (done_res) begin
          commands_done++;
          if (present) presence_seen++;
        end
        if (tick_results.size() == 0) begin
          $error("result transfer with no tick outstanding");
          errors++;
        end else begin
          want = tick_results.pop_front();
          check_field("dq_pull_low", 16'(want.dq_pull_low), 16'(dq_pull_low));
          check_field("busy_res", 16'(want.busy_res), 16'(busy_res));
          check_field("done_res", 16'(want.done_res), 16'(done_res));
          check_field("present", 16'(want.present), 16'(present));
          check_field("read_data", 16'(want.read_data), 16'(read_data));
          check_field("temperature", want.temperature, temperature);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sensor = fresh_state();
    lookahead = fresh_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Power-on slot timings, checked without touching the registers.
    set_idling(30, 50);
    queue_command(OP_READ, 8'($urandom));
    queue_command(OP_WRITE, 8'hA5);

    // All timings zero: every slot lasts one tick and the post-reset wait is skipped.
    program_regs(0, 0, 0, 0);
    presence_pct = 100;
    bit_mode = BITS_HIGH;
    queue_command(OP_RESET, 8'h00);
    queue_command(OP_WRITE, 8'h00);
    queue_command(OP_WRITE, 8'hFF);
    queue_command(OP_READ, 8'h00);
    queue_command(OP_READ_TEMP, 8'h00);
    queue_command(OP_CONVERT, 8'h00);
    queue_command(OP_CONFIGURE, 8'h00);
    bit_mode = BITS_LOW;
    queue_command(OP_READ, 8'hFF);
    presence_pct = 0;
    queue_command(OP_RESET, 8'h00);
    queue_command(OP_READ_TEMP, 8'h00);
    queue_command(OP_CONVERT, 8'h00);
    queue_command(OP_CONFIGURE, 8'h00);
    queue_command(OP_BAD_LO, 8'hFF);
    queue_command(OP_BAD_HI, 8'h00);
    presence_pct = 80;
    bit_mode = BITS_RANDOM;

    program_regs(1, 3, 1, 3);
    queue_random(150);

    program_regs(0, 4, 0, 4);
    set_idling(50, 30);
    queue_random(150);

    program_regs(1, 1, 1, 1);
    set_idling(0, 0);
    queue_random(150);

    settle();
    $display("Checked %0d bus ticks under %0d timing settings.", ticks_done, settings_run);
    $display("%0d commands completed, %0d of them with a presence pulse.",
             commands_done, presence_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
